// File: rtl/icfe_pkg.sv
// Package for the impedance command frame encoder.
// Holds the item and register types, code widths, register indexes and helpers.
// No dependencies.
package icfe_pkg;

  localparam int POSITION_BITS = 16;
  localparam int SPEED_BITS = 12;
  localparam int DAMPING_BITS = 9;
  localparam int TORQUE_BITS = 12;
  localparam int STIFF_BITS = 12;

  localparam logic [31:0] STIFF_MAX = 32'd32768000;
  localparam logic [31:0] DAMP_MAX = 32'd327680;

  // The gain ranges are a power of two times 125 and times 5. The power of two
  // is a shift and the odd factor is a reciprocal multiplication, exact here.
  localparam int STIFF_SHIFT = 18;
  localparam logic [19:0] STIFF_REC = 20'd536871;
  localparam int STIFF_REC_SHIFT = 26;
  localparam int DAMP_SHIFT = 16;
  localparam logic [11:0] DAMP_REC = 12'd3277;
  localparam int DAMP_REC_SHIFT = 14;

  localparam int NUM_W = 48;
  localparam int DEN_W = 32;
  localparam int QUO_W = 16;
  localparam int DIV_STAGES = QUO_W;
  localparam int LATENCY = DIV_STAGES + 7;

  localparam logic [31:0] DIV10_MUL = 32'd3435973836;
  localparam int DIV10_SHIFT = 35;

  localparam logic [1:0] MODE_OPEN = 2'd0;
  localparam logic [1:0] MODE_CLOSED = 2'd1;
  localparam logic [1:0] MODE_IMPEDANCE = 2'd2;
  localparam logic [1:0] MODE_SILENT = 2'd3;

  localparam logic [2:0] REG_DRIVE_MODE = 3'd0;
  localparam logic [2:0] REG_POSITION_LIMIT = 3'd1;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd2;
  localparam logic [2:0] REG_TORQUE_LIMIT = 3'd3;
  localparam logic [2:0] REG_ZERO_OFFSET = 3'd4;
  localparam logic [2:0] REG_COULOMB_FRICTION = 3'd5;
  localparam logic [2:0] REG_VISCOUS_FRICTION = 3'd6;
  localparam logic [2:0] REG_INERTIA = 3'd7;

  typedef struct packed {
    logic signed [31:0] target_torque;
    logic signed [31:0] target_position;
    logic signed [31:0] target_speed;
    logic signed [31:0] stiffness_gain;
    logic signed [31:0] damping_gain;
    logic signed [31:0] measured_torque;
    logic signed [31:0] measured_speed;
    logic signed [31:0] measured_accel;
    logic               drive_enabled;
    logic               feedback_present;
  } cmd_in_t;

  typedef struct packed {
    logic [63:0]        command_frame;
    logic signed [31:0] control_torque;
  } cmd_out_t;

  typedef struct packed {
    logic [1:0]         drive_mode;
    logic [30:0]        position_limit;
    logic [30:0]        speed_limit;
    logic [30:0]        torque_limit;
    logic signed [31:0] zero_offset;
    logic signed [31:0] coulomb_friction;
    logic signed [31:0] viscous_friction;
    logic signed [31:0] inertia;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] torque;
    logic signed [31:0] kp;
    logic signed [31:0] kd;
    logic signed [32:0] pos_sum;
    logic signed [31:0] speed;
  } torq_t;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -51'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Clamps x to [-l, l] and returns the offset from -l.
  function automatic logic [31:0] clamp_sym(input logic signed [32:0] x,
                                            input logic [30:0] l);
    logic signed [32:0] ls;
    logic signed [32:0] sum;
    logic [31:0] r;
    ls = $signed({2'b00, l});
    sum = x + ls;
    if (x > ls) begin
      r = {l, 1'b0};
    end else if (x < -ls) begin
      r = '0;
    end else begin
      r = sum[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp_gain(input logic signed [31:0] x,
                                             input logic [31:0] mx);
    logic [31:0] r;
    if (x[31]) begin
      r = '0;
    end else if ($unsigned(x) > mx) begin
      r = mx;
    end else begin
      r = $unsigned(x);
    end
    return r;
  endfunction

  function automatic logic [30:0] fix_limit(input logic [30:0] l);
    return (l == '0) ? 31'd1 : l;
  endfunction

endpackage

// File: rtl/icfe_torque.sv
// Torque stages of the encoder: error, friction, inertia and mode selection.
// Four register stages. Uses icfe_pkg.
module icfe_torque (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  icfe_pkg::cmd_in_t in_item,
  input  icfe_pkg::cfg_t  cfg,
  output logic            out_valid,
  output icfe_pkg::torq_t out_data
);

  logic v0, v1, v2, v3;
  icfe_pkg::cmd_in_t i0;

  logic               en1, en2;
  logic signed [31:0] t1, t2;
  logic signed [31:0] kp1, kp2, kd1, kd2, sp1, sp2;
  logic signed [32:0] pos1, pos2;
  logic [32:0]        aerr1, aerr2;
  logic               eneg1, eneg2;
  logic signed [63:0] pv1, pa1;
  logic signed [33:0] coul1;
  logic [29:0]        q0_2;
  logic signed [50:0] imp2;

  logic signed [32:0] err_c;
  logic signed [32:0] cmag_c;
  logic [64:0]        prod_c;
  logic [33:0]        rem_c;
  logic [29:0]        q_c;
  logic signed [50:0] closed_c;
  logic signed [31:0] torque_c;
  logic               gains_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2 && !(en2 && cfg.drive_mode == icfe_pkg::MODE_SILENT);
    end
  end

  always_comb begin
    err_c = {i0.target_torque[31], i0.target_torque}
          - {i0.measured_torque[31], i0.measured_torque};
    cmag_c = cfg.coulomb_friction[31]
           ? -{cfg.coulomb_friction[31], cfg.coulomb_friction}
           : {cfg.coulomb_friction[31], cfg.coulomb_friction};
  end

  always_ff @(posedge clk) begin
    i0 <= in_item;
    en1 <= i0.drive_enabled && i0.feedback_present;
    t1 <= i0.target_torque;
    kp1 <= i0.stiffness_gain;
    kd1 <= i0.damping_gain;
    sp1 <= i0.target_speed;
    pos1 <= {i0.target_position[31], i0.target_position}
          + {cfg.zero_offset[31], cfg.zero_offset};
    eneg1 <= err_c[32];
    aerr1 <= err_c[32] ? $unsigned(-err_c) : $unsigned(err_c);
    pv1 <= cfg.viscous_friction * i0.measured_speed;
    pa1 <= cfg.inertia * i0.measured_accel;
    coul1 <= i0.measured_speed[31] ? -{cmag_c[32], cmag_c} : {cmag_c[32], cmag_c};
  end

  assign prod_c = {32'd0, aerr1} * {33'd0, icfe_pkg::DIV10_MUL};

  always_ff @(posedge clk) begin
    en2 <= en1;
    t2 <= t1;
    kp2 <= kp1;
    kd2 <= kd1;
    sp2 <= sp1;
    pos2 <= pos1;
    eneg2 <= eneg1;
    aerr2 <= aerr1;
    q0_2 <= prod_c[icfe_pkg::DIV10_SHIFT +: 30];
    imp2 <= {{19{t1[31]}}, t1} + {{17{coul1[33]}}, coul1}
          + {{3{pv1[63]}}, pv1[63:16]} + {{3{pa1[63]}}, pa1[63:16]};
  end

  always_comb begin
    rem_c = {1'b0, aerr2} - ({4'd0, q0_2} * 34'd10);
    q_c = q0_2 + ((rem_c >= 34'd10) ? 30'd1 : 30'd0);
    closed_c = eneg2 ? ({{19{t2[31]}}, t2} - {21'd0, q_c})
                     : ({{19{t2[31]}}, t2} + {21'd0, q_c});
    gains_on = en2 && cfg.drive_mode == icfe_pkg::MODE_IMPEDANCE;
    if (!en2) begin
      torque_c = '0;
    end else begin
      case (cfg.drive_mode)
        icfe_pkg::MODE_OPEN:      torque_c = t2;
        icfe_pkg::MODE_CLOSED:    torque_c = icfe_pkg::sat32(closed_c);
        icfe_pkg::MODE_IMPEDANCE: torque_c = icfe_pkg::sat32(imp2);
        default:                  torque_c = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_data.torque <= torque_c;
    out_data.kp <= gains_on ? kp2 : 32'sd0;
    out_data.kd <= gains_on ? kd2 : 32'sd0;
    out_data.pos_sum <= pos2;
    out_data.speed <= sp2;
  end

  assign out_valid = v3;

endmodule

// File: rtl/icfe_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in QUO_W bits. Uses icfe_pkg.
module icfe_div (
  input  logic                          clk,
  input  logic [icfe_pkg::NUM_W-1:0]    num,
  input  logic [icfe_pkg::DEN_W-1:0]    den,
  output logic [icfe_pkg::QUO_W-1:0]    quo
);

  localparam int NW = icfe_pkg::NUM_W;
  localparam int DW = icfe_pkg::DEN_W;
  localparam int QW = icfe_pkg::QUO_W;
  localparam int NS = icfe_pkg::DIV_STAGES;

  logic [DW-1:0] rem [1:NS];
  logic [QW-1:0] low [1:NS];
  logic [DW-1:0] dd  [1:NS];
  logic [QW-1:0] qq  [1:NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] dd_in;
    logic [QW-1:0] qq_in;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num[NW-1:QW];
      assign low_in = num[QW-1:0];
      assign dd_in = den;
      assign qq_in = '0;
    end else begin : g_next
      assign rem_in = rem[k];
      assign low_in = low[k];
      assign dd_in = dd[k];
      assign qq_in = qq[k];
    end

    assign sh = {rem_in, low_in[QW-1]};
    assign ge = sh >= {1'b0, dd_in};
    assign diff = sh - {1'b0, dd_in};

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? diff[DW-1:0] : sh[DW-1:0];
      low[k+1] <= {low_in[QW-2:0], 1'b0};
      dd[k+1] <= dd_in;
      qq[k+1] <= {qq_in[QW-2:0], ge};
    end
  end

  assign quo = qq[NS];

endmodule

// File: rtl/impedance_command_frame_encoder_unit.sv
// Top level of the impedance command frame encoder: registers, scaling, frame packing.
// Uses icfe_pkg, icfe_torque and icfe_div.
//
//   channel  signals                           transfer when
//   input    start, busy, item                 start high and busy low
//   config   cfg_valid, cfg_ready, cfg_index,  cfg_valid and cfg_ready high
//            cfg_data
//   result   done, result                      done high, one cycle
//
// A new item may be started in every cycle while busy is low; done and the result
// appear together from the output register.
// The pipeline is four torque stages, two scaling stages, the 16-stage divider for the
// position, speed and torque codes, and the output register.
// Reset clears the valid bits and loads the register defaults; busy is high in reset.
// The result side cannot stall, so the pipeline never holds.
module impedance_command_frame_encoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  icfe_pkg::cmd_in_t  item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output icfe_pkg::cmd_out_t result
);

  localparam int NS = icfe_pkg::DIV_STAGES;
  localparam int NW = icfe_pkg::NUM_W;

  icfe_pkg::cfg_t  cfg;
  icfe_pkg::torq_t tq;
  logic            tq_valid;
  logic            accept;

  logic v4, v5;
  logic signed [31:0] torque4, torque5;
  logic [31:0] dp4, dv4, dt4, dkp4, dkd4;
  logic [31:0] den_p4, den_v4, den_t4;
  logic [NW-1:0] np5, nv5, nt5, nkp5, nkd5;
  logic [31:0] den_p5, den_v5, den_t5;

  logic [38:0] kp_prod;
  logic [23:0] kd_prod;

  logic               vline [1:NS];
  logic signed [31:0] tline [1:NS];
  logic [11:0]        kline [1:NS];
  logic [8:0]         dline [1:NS];

  logic [15:0] qp, qv, qt;
  logic [11:0] qkp;
  logic [8:0]  qkd;

  assign accept = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_mode <= icfe_pkg::MODE_OPEN;
      cfg.position_limit <= 31'd823855;
      cfg.speed_limit <= 31'd655360;
      cfg.torque_limit <= 31'd655360;
      cfg.zero_offset <= '0;
      cfg.coulomb_friction <= '0;
      cfg.viscous_friction <= '0;
      cfg.inertia <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        icfe_pkg::REG_DRIVE_MODE:       cfg.drive_mode <= cfg_data[1:0];
        icfe_pkg::REG_POSITION_LIMIT:   cfg.position_limit <= cfg_data[30:0];
        icfe_pkg::REG_SPEED_LIMIT:      cfg.speed_limit <= cfg_data[30:0];
        icfe_pkg::REG_TORQUE_LIMIT:     cfg.torque_limit <= cfg_data[30:0];
        icfe_pkg::REG_ZERO_OFFSET:      cfg.zero_offset <= cfg_data;
        icfe_pkg::REG_COULOMB_FRICTION: cfg.coulomb_friction <= cfg_data;
        icfe_pkg::REG_VISCOUS_FRICTION: cfg.viscous_friction <= cfg_data;
        icfe_pkg::REG_INERTIA:          cfg.inertia <= cfg_data;
        default: ;
      endcase
    end
  end

  icfe_torque u_torque (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_item  (item),
    .cfg      (cfg),
    .out_valid(tq_valid),
    .out_data (tq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v4 <= tq_valid;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    torque4 <= tq.torque;
    dp4 <= icfe_pkg::clamp_sym(tq.pos_sum, icfe_pkg::fix_limit(cfg.position_limit));
    dv4 <= icfe_pkg::clamp_sym({tq.speed[31], tq.speed},
                               icfe_pkg::fix_limit(cfg.speed_limit));
    dt4 <= icfe_pkg::clamp_sym({tq.torque[31], tq.torque},
                               icfe_pkg::fix_limit(cfg.torque_limit));
    dkp4 <= icfe_pkg::clamp_gain(tq.kp, icfe_pkg::STIFF_MAX);
    dkd4 <= icfe_pkg::clamp_gain(tq.kd, icfe_pkg::DAMP_MAX);
    den_p4 <= {icfe_pkg::fix_limit(cfg.position_limit), 1'b0};
    den_v4 <= {icfe_pkg::fix_limit(cfg.speed_limit), 1'b0};
    den_t4 <= {icfe_pkg::fix_limit(cfg.torque_limit), 1'b0};
  end

  always_ff @(posedge clk) begin
    torque5 <= torque4;
    np5 <= ({16'd0, dp4} << icfe_pkg::POSITION_BITS) - {16'd0, dp4};
    nv5 <= ({16'd0, dv4} << icfe_pkg::SPEED_BITS) - {16'd0, dv4};
    nt5 <= ({16'd0, dt4} << icfe_pkg::TORQUE_BITS) - {16'd0, dt4};
    nkp5 <= ({16'd0, dkp4} << icfe_pkg::STIFF_BITS) - {16'd0, dkp4};
    nkd5 <= ({16'd0, dkd4} << icfe_pkg::DAMPING_BITS) - {16'd0, dkd4};
    den_p5 <= den_p4;
    den_v5 <= den_v4;
    den_t5 <= den_t4;
  end

  icfe_div u_div_p  (.clk(clk), .num(np5),  .den(den_p5), .quo(qp));
  icfe_div u_div_v  (.clk(clk), .num(nv5),  .den(den_v5), .quo(qv));
  icfe_div u_div_t  (.clk(clk), .num(nt5),  .den(den_t5), .quo(qt));

  assign kp_prod = {20'd0, nkp5[icfe_pkg::STIFF_SHIFT +: 19]} * {19'd0, icfe_pkg::STIFF_REC};
  assign kd_prod = {12'd0, nkd5[icfe_pkg::DAMP_SHIFT +: 12]} * {12'd0, icfe_pkg::DAMP_REC};

  for (genvar k = 1; k <= NS; k++) begin : g_line
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vline[k] <= 1'b0;
        end else begin
          vline[k] <= v5;
        end
        tline[k] <= torque5;
        kline[k] <= kp_prod[icfe_pkg::STIFF_REC_SHIFT +: 12];
        dline[k] <= kd_prod[icfe_pkg::DAMP_REC_SHIFT +: 9];
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          vline[k] <= 1'b0;
        end else begin
          vline[k] <= vline[k-1];
        end
        tline[k] <= tline[k-1];
        kline[k] <= kline[k-1];
        dline[k] <= dline[k-1];
      end
    end
  end

  assign qkp = kline[NS];
  assign qkd = dline[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vline[NS];
    end
    result.control_torque <= tline[NS];
    result.command_frame <= {3'd0, qkp[11:7],
                             qkp[6:0], qkd[8],
                             qkd[7:0],
                             qp[15:8],
                             qp[7:0],
                             qv[11:4],
                             qv[3:0], qt[11:8],
                             qt[7:0]};
  end

  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, icfe_pkg::LATENCY))
    else $error("Result strobe without a matching input transfer.");

  a_gains_only_impedance: assert property (@(posedge clk) disable iff (rst)
    (done && cfg.drive_mode != icfe_pkg::MODE_IMPEDANCE)
      |-> result.command_frame[63:40] == 24'd0)
    else $error("Gain codes nonzero outside impedance mode.");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("Result strobe right after reset.");

endmodule
